// ===== hw/rtl/brss_pkg.sv =====
// Shared types and codes for the block range sum store.
package brss_pkg;

  localparam int FIELD_W    = 11;
  localparam int DATA_W     = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LENGTH  = 2'd1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [FIELD_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [FIELD_W-1:0] BLOCK_RESET = 11'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ASEEK,
    ST_AUPD,
    ST_APRE,
    ST_APFX,
    ST_AACC,
    ST_QHI,
    ST_QHLD,
    ST_QLO,
    ST_QSUB,
    ST_QWALK,
    ST_QT0,
    ST_QT1,
    ST_QT2
  } state_t;

endpackage

// ===== hw/rtl/block_range_sum_store.sv =====
// Block range sum store: sequencer, shared 64-bit adder and two element/prefix memories.
//
//   channel | ports                                           | handshake
//   --------+-------------------------------------------------+---------------------------
//   input   | in_mode in_position in_end_position in_amount   | start & !busy
//   result  | out_range_sum out_range_error                   | out_valid, one cycle
//   config  | cfg_index cfg_wdata                             | cfg_we, no wait
//
// Add: a block seek walk finds the position's block, the element is updated, then the
// later prefix entries of that block are refreshed through the shared adder.
// Query: reads prefix at hi and lo, then walks the blocks; one read port per memory.
// Invalid query: result in the next cycle. Add out of range: dropped. After reset and
// after each element count or block length write, a clearing pass of MAX_ELEMENTS+1
// entries runs with busy high. The receiver cannot stall; results are never held.
module block_range_sum_store #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [brss_pkg::FIELD_W-1:0]        in_position,
  input  logic [brss_pkg::FIELD_W-1:0]        in_end_position,
  input  logic signed [brss_pkg::DATA_W-1:0]  in_amount,
  output logic                                out_valid,
  output logic signed [brss_pkg::DATA_W-1:0]  out_range_sum,
  output logic                                out_range_error,
  input  logic                                cfg_we,
  input  logic [brss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [brss_pkg::FIELD_W-1:0]        cfg_wdata
);

  localparam int DEPTH = MAX_ELEMENTS + 1;
  localparam int AW    = $clog2(MAX_ELEMENTS + 1);
  localparam int SW    = $clog2(MAX_ELEMENTS + 2049);
  localparam int DW    = brss_pkg::DATA_W;
  localparam int FW    = brss_pkg::FIELD_W;

  brss_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [FW-1:0] count_r, count_nxt;
  logic [FW-1:0] blen_r, blen_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] e_r, e_nxt;
  logic [SW-1:0] lo_r, lo_nxt;
  logic [SW-1:0] hi_r, hi_nxt;
  logic [DW-1:0] amt_r, amt_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_sum_r, out_sum_nxt;
  logic          out_err_r, out_err_nxt;

  logic [DW-1:0] val_mem [DEPTH];
  logic [DW-1:0] pre_mem [DEPTH];
  logic [DW-1:0] val_q, pre_q;
  logic          val_we, pre_we;
  logic [AW-1:0] val_wa, pre_wa;
  logic [DW-1:0] val_wd, pre_wd;

  logic [DW-1:0] add_a, add_b, add_sum;
  logic          add_sub;

  logic [SW-1:0] n_eff, b_eff, pos_ext, end_ext, t_sum, t_m1, next_k;
  logic          k_ok, cfg_hit, accept, add_drop, query_err;

  assign pos_ext = {{(SW-FW){1'b0}}, in_position};
  assign end_ext = {{(SW-FW){1'b0}}, in_end_position};
  assign n_eff   = ({{(SW-FW){1'b0}}, count_r} > SW'(MAX_ELEMENTS)) ?
                   SW'(MAX_ELEMENTS) : {{(SW-FW){1'b0}}, count_r};
  assign b_eff   = (blen_r == '0) ? SW'(1) : {{(SW-FW){1'b0}}, blen_r};
  assign t_sum   = s_r + b_eff;
  assign t_m1    = t_sum - SW'(1);
  assign next_k  = (state_r == brss_pkg::ST_APRE) ? lo_r + SW'(1) : idx_r + SW'(1);
  assign k_ok    = (next_k < e_r) && (next_k <= n_eff);

  assign cfg_hit   = cfg_we && ((cfg_index == brss_pkg::CFG_ELEMENT_COUNT) ||
                                (cfg_index == brss_pkg::CFG_BLOCK_LENGTH));
  assign busy      = (state_r != brss_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign add_drop  = (pos_ext >= n_eff);
  assign query_err = (pos_ext > end_ext) || (end_ext > n_eff);

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(DW-1){1'b0}}, add_sub};

  assign out_valid       = out_valid_r;
  assign out_range_sum   = out_sum_r;
  assign out_range_error = out_err_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brss_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == brss_pkg::MODE_ADD) begin
            state_nxt = add_drop ? brss_pkg::ST_IDLE : brss_pkg::ST_ASEEK;
          end else begin
            state_nxt = query_err ? brss_pkg::ST_IDLE : brss_pkg::ST_QHI;
          end
        end
      end
      brss_pkg::ST_CLEAR: begin
        if (clr_r == AW'(MAX_ELEMENTS)) state_nxt = brss_pkg::ST_IDLE;
      end
      brss_pkg::ST_ASEEK: begin
        if (t_sum > lo_r) state_nxt = brss_pkg::ST_AUPD;
      end
      brss_pkg::ST_AUPD:  state_nxt = brss_pkg::ST_APRE;
      brss_pkg::ST_APRE:  state_nxt = k_ok ? brss_pkg::ST_APFX : brss_pkg::ST_IDLE;
      brss_pkg::ST_APFX:  state_nxt = brss_pkg::ST_AACC;
      brss_pkg::ST_AACC:  state_nxt = k_ok ? brss_pkg::ST_APFX : brss_pkg::ST_IDLE;
      brss_pkg::ST_QHI:   state_nxt = brss_pkg::ST_QHLD;
      brss_pkg::ST_QHLD:  state_nxt = brss_pkg::ST_QLO;
      brss_pkg::ST_QLO:   state_nxt = brss_pkg::ST_QSUB;
      brss_pkg::ST_QSUB:  state_nxt = brss_pkg::ST_QWALK;
      brss_pkg::ST_QWALK: begin
        if (t_sum > hi_r) begin
          state_nxt = brss_pkg::ST_IDLE;
        end else if (t_sum > lo_r) begin
          state_nxt = brss_pkg::ST_QT0;
        end
      end
      brss_pkg::ST_QT0:   state_nxt = brss_pkg::ST_QT1;
      brss_pkg::ST_QT1:   state_nxt = brss_pkg::ST_QT2;
      brss_pkg::ST_QT2:   state_nxt = brss_pkg::ST_QWALK;
      default:            state_nxt = brss_pkg::ST_IDLE;
    endcase
    if (cfg_hit) state_nxt = brss_pkg::ST_CLEAR;
  end

  always_comb begin
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    blen_nxt      = blen_r;
    idx_nxt       = idx_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    amt_nxt       = amt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    val_we        = 1'b0;
    val_wa        = idx_r[AW-1:0];
    val_wd        = add_sum;
    pre_we        = 1'b0;
    pre_wa        = idx_r[AW-1:0];
    pre_wd        = acc_r;
    add_a         = acc_r;
    add_b         = val_q;
    add_sub       = 1'b0;
    case (state_r)
      brss_pkg::ST_IDLE: begin
        if (accept) begin
          lo_nxt  = pos_ext;
          hi_nxt  = end_ext;
          amt_nxt = in_amount;
          s_nxt   = '0;
          if (in_mode == brss_pkg::MODE_ADD) begin
            idx_nxt = pos_ext;
          end else if (query_err) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = '0;
            out_err_nxt   = 1'b1;
          end else begin
            idx_nxt = end_ext;
          end
        end
      end
      brss_pkg::ST_CLEAR: begin
        val_we  = 1'b1;
        val_wa  = clr_r;
        val_wd  = '0;
        pre_we  = 1'b1;
        pre_wa  = clr_r;
        pre_wd  = '0;
        clr_nxt = clr_r + AW'(1);
      end
      brss_pkg::ST_ASEEK: begin
        if (t_sum > lo_r) begin
          e_nxt = t_sum;
        end else begin
          s_nxt = t_sum;
        end
      end
      brss_pkg::ST_AUPD: begin
        add_a   = amt_r;
        add_b   = val_q;
        val_we  = 1'b1;
        acc_nxt = add_sum;
      end
      brss_pkg::ST_APRE: begin
        add_b   = pre_q;
        acc_nxt = add_sum;
        idx_nxt = next_k;
      end
      brss_pkg::ST_APFX: begin
        pre_we = 1'b1;
      end
      brss_pkg::ST_AACC: begin
        add_b   = val_q;
        acc_nxt = add_sum;
        idx_nxt = next_k;
      end
      brss_pkg::ST_QHLD: begin
        add_a   = '0;
        add_b   = pre_q;
        acc_nxt = add_sum;
        idx_nxt = lo_r;
      end
      brss_pkg::ST_QSUB: begin
        add_b   = pre_q;
        add_sub = 1'b1;
        acc_nxt = add_sum;
      end
      brss_pkg::ST_QWALK: begin
        if (t_sum > hi_r) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          out_err_nxt   = 1'b0;
        end else begin
          s_nxt = t_sum;
          if (t_sum > lo_r) idx_nxt = t_m1;
        end
      end
      brss_pkg::ST_QT1: begin
        add_b   = val_q;
        acc_nxt = add_sum;
      end
      brss_pkg::ST_QT2: begin
        add_b   = pre_q;
        acc_nxt = add_sum;
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      case (cfg_index)
        brss_pkg::CFG_ELEMENT_COUNT: count_nxt = cfg_wdata;
        brss_pkg::CFG_BLOCK_LENGTH:  blen_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end
    if (cfg_hit) clr_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brss_pkg::ST_CLEAR;
      clr_r       <= '0;
      count_r     <= brss_pkg::COUNT_RESET;
      blen_r      <= brss_pkg::BLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      blen_r      <= blen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    amt_r     <= amt_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_q <= val_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pre_we) pre_mem[pre_wa] <= pre_wd;
    pre_q <= pre_mem[idx_r[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == brss_pkg::MODE_ADD)) |=> !out_valid)
    else $error("add transaction produced a result");

  a_reversed_query: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == brss_pkg::MODE_QUERY) && (in_position > in_end_position))
    |=> (out_valid && out_range_error && (out_range_sum == '0)))
    else $error("reversed query range not flagged");

  a_sum_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |-> $past(state_r == brss_pkg::ST_QWALK))
    else $error("valid sum not produced by block walk");

  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brss_pkg::ST_CLEAR) |-> (clr_r <= AW'(MAX_ELEMENTS)))
    else $error("clearing pass ran past the store");
`endif

endmodule
